// ===== rtl/core/steq_pkg.sv =====
// Shared types and constants for the sorted timer event queue.
// Holds field widths, opcode and result codes, and controller/datapath structs.
package steq_pkg;

    localparam int MAX_TIMERS_DEF = 32;
    localparam int DUE_W          = 48;
    localparam int ID_W           = 32;
    localparam int ENTRY_W        = DUE_W + 2 * ID_W;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    typedef enum logic [1:0] {
        OP_SET      = 2'd0,
        OP_CANCEL   = 2'd1,
        OP_DISPATCH = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_FIRED  = 2'd1,
        KIND_NONE   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        OFF_ZERO = 2'd0,
        OFF_ONE  = 2'd1,
        OFF_DOWN = 2'd2,
        OFF_POP  = 2'd3
    } t_off;

    typedef enum logic [1:0] {
        OUT_OK   = 2'd0,
        OUT_ERR  = 2'd1,
        OUT_PEND = 2'd2,
        OUT_NONE = 2'd3
    } t_out_sel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_DEL_RD,
        S_DEL_WR,
        S_AFTER_RM,
        S_INS_RD,
        S_INS_CHK,
        S_UP_RD,
        S_UP_WR,
        S_INS_WR,
        S_RESP_OK,
        S_RESP_ERR,
        S_DSP_RD,
        S_DSP_CHK,
        S_DSP_END,
        S_CMP_RD,
        S_CMP_WR
    } t_state;

    typedef struct packed {
        logic     load_item;
        logic     idx_clr;
        logic     idx_inc;
        logic     idx_dec;
        logic     idx_load_cnt;
        logic     pos_load;
        logic     k_load;
        logic     found_set;
        logic     pend_load;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     cnt_sub_k;
        logic     wr_en;
        logic     wr_new;
        logic     out_load;
        logic     out_last;
        t_off     off;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic idx_eq_cnt;
        logic idx_last;
        logic idx_gt_pos;
        logic cmp_done;
        logic key_match;
        logic due_le_new;
        logic due_le_now;
        logic cb_zero;
        logic full;
        logic found;
        logic pend_v;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/core/steq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module steq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/steq_ctrl.sv =====
// Controller state machine for the sorted timer event queue.
// Uses steq_pkg; drives t_cmd to steq_dp and reads back t_sts.
module steq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  steq_pkg::t_sts  i_sts,
    output logic            o_ready,
    output steq_pkg::t_cmd  o_cmd
);
    import steq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_item = 1'b1;
                    o_cmd.idx_clr   = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.op)
                    OP_SET, OP_CANCEL: n_state = S_SRCH_RD;
                    OP_DISPATCH:       n_state = S_DSP_RD;
                    default:           n_state = S_RESP_ERR;
                endcase
            end
            S_SRCH_RD: begin
                o_cmd.off = OFF_ZERO;
                n_state   = i_sts.idx_eq_cnt ? S_AFTER_RM : S_SRCH_CHK;
            end
            S_SRCH_CHK: begin
                o_cmd.off = OFF_ZERO;
                if (i_sts.key_match) begin
                    o_cmd.found_set = 1'b1;
                    n_state         = S_DEL_RD;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SRCH_RD;
                end
            end
            S_DEL_RD: begin
                o_cmd.off = OFF_ONE;
                if (i_sts.idx_last) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_AFTER_RM;
                end else begin
                    n_state = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                o_cmd.off     = OFF_ONE;
                o_cmd.wr_en   = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state       = S_DEL_RD;
            end
            S_AFTER_RM: begin
                if (i_sts.op == OP_CANCEL) begin
                    n_state = i_sts.found ? S_RESP_OK : S_RESP_ERR;
                end else if (i_sts.cb_zero || (!i_sts.found && i_sts.full)) begin
                    n_state = S_RESP_ERR;
                end else begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_INS_RD;
                end
            end
            S_INS_RD: begin
                o_cmd.off = OFF_ZERO;
                if (i_sts.idx_eq_cnt) begin
                    o_cmd.pos_load     = 1'b1;
                    o_cmd.idx_load_cnt = 1'b1;
                    n_state            = S_UP_RD;
                end else begin
                    n_state = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                o_cmd.off = OFF_ZERO;
                if (i_sts.due_le_new) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_INS_RD;
                end else begin
                    o_cmd.pos_load     = 1'b1;
                    o_cmd.idx_load_cnt = 1'b1;
                    n_state            = S_UP_RD;
                end
            end
            S_UP_RD: begin
                o_cmd.off = OFF_DOWN;
                n_state   = i_sts.idx_gt_pos ? S_UP_WR : S_INS_WR;
            end
            S_UP_WR: begin
                o_cmd.off     = OFF_DOWN;
                o_cmd.wr_en   = 1'b1;
                o_cmd.idx_dec = 1'b1;
                n_state       = S_UP_RD;
            end
            S_INS_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_new  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                n_state       = S_RESP_OK;
            end
            S_RESP_OK: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_OK;
                    n_state        = S_IDLE;
                end
            end
            S_RESP_ERR: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_ERR;
                    n_state        = S_IDLE;
                end
            end
            S_DSP_RD: begin
                o_cmd.off = OFF_ZERO;
                n_state   = i_sts.idx_eq_cnt ? S_DSP_END : S_DSP_CHK;
            end
            S_DSP_CHK: begin
                o_cmd.off = OFF_ZERO;
                if (!i_sts.due_le_now) begin
                    n_state = S_DSP_END;
                end else if (!i_sts.pend_v) begin
                    o_cmd.pend_load = 1'b1;
                    o_cmd.idx_inc   = 1'b1;
                    n_state         = S_DSP_RD;
                end else if (i_sts.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_sel   = OUT_PEND;
                    o_cmd.pend_load = 1'b1;
                    o_cmd.idx_inc   = 1'b1;
                    n_state         = S_DSP_RD;
                end
            end
            S_DSP_END: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = i_sts.pend_v ? OUT_PEND : OUT_NONE;
                    o_cmd.out_last = 1'b1;
                    o_cmd.k_load   = 1'b1;
                    n_state        = S_CMP_RD;
                end
            end
            S_CMP_RD: begin
                o_cmd.off = OFF_POP;
                if (i_sts.cmp_done) begin
                    o_cmd.cnt_sub_k = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    n_state = S_CMP_WR;
                end
            end
            S_CMP_WR: begin
                o_cmd.off     = OFF_POP;
                o_cmd.wr_en   = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state       = S_CMP_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/steq_dp.sv =====
// Datapath for the sorted timer event queue: item registers, pointers,
// entry count, entry RAM and output register. Uses steq_pkg and steq_ram.
module steq_dp #(
    parameter int MAX_TIMERS = steq_pkg::MAX_TIMERS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  steq_pkg::t_cmd              i_cmd,
    output steq_pkg::t_sts              o_sts,
    input  logic [1:0]                  i_opcode,
    input  logic [steq_pkg::DUE_W-1:0]  i_now_ms,
    input  logic [steq_pkg::ID_W-1:0]   i_period_ms,
    input  logic [steq_pkg::ID_W-1:0]   i_callback_id,
    input  logic [steq_pkg::ID_W-1:0]   i_context_id,
    input  logic                        i_out_stall,
    output logic                        o_valid,
    output logic [1:0]                  o_kind,
    output logic                        o_status,
    output logic [steq_pkg::ID_W-1:0]   o_fired_callback,
    output logic [steq_pkg::ID_W-1:0]   o_fired_context,
    output logic                        o_last
);
    import steq_pkg::*;

    localparam int AW = $clog2(MAX_TIMERS);
    localparam int CW = $clog2(MAX_TIMERS + 1);

    t_op              r_op;
    logic [DUE_W-1:0] r_now;
    logic [DUE_W-1:0] r_due;
    logic [ID_W-1:0]  r_cb;
    logic [ID_W-1:0]  r_ctx;
    logic [CW-1:0]    r_idx;
    logic [CW-1:0]    r_pos;
    logic [CW-1:0]    r_k;
    logic [CW-1:0]    r_cnt;
    logic             r_found;
    logic             r_pend_v;
    logic [ID_W-1:0]  r_pend_cb;
    logic [ID_W-1:0]  r_pend_ctx;
    logic             r_o_valid;
    t_kind            r_kind;
    logic             r_status;
    logic [ID_W-1:0]  r_o_cb;
    logic [ID_W-1:0]  r_o_ctx;
    logic             r_last;

    logic [DUE_W:0]     due_sum;
    logic [CW-1:0]      off_val;
    logic [CW-1:0]      rd_idx;
    logic [ENTRY_W-1:0] rd_data;
    logic [ENTRY_W-1:0] wr_data;
    logic [DUE_W-1:0]   rd_due;
    logic [ID_W-1:0]    rd_cb;
    logic [ID_W-1:0]    rd_ctx;
    logic               out_free;

    assign due_sum = {1'b0, i_now_ms} + {{(DUE_W - ID_W + 1){1'b0}}, i_period_ms};

    always_comb begin
        case (i_cmd.off)
            OFF_ZERO: off_val = '0;
            OFF_ONE:  off_val = CW'(1);
            OFF_DOWN: off_val = '1;
            OFF_POP:  off_val = r_k;
            default:  off_val = '0;
        endcase
    end

    assign rd_idx  = r_idx + off_val;
    assign rd_due  = rd_data[ENTRY_W-1 -: DUE_W];
    assign rd_cb   = rd_data[2*ID_W-1 -: ID_W];
    assign rd_ctx  = rd_data[ID_W-1:0];
    assign wr_data = i_cmd.wr_new ? {r_due, r_cb, r_ctx} : rd_data;

    steq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TIMERS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (r_idx[AW-1:0]),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op  <= t_op'(i_opcode);
            r_now <= i_now_ms;
            r_due <= due_sum[DUE_W] ? '1 : due_sum[DUE_W-1:0];
            r_cb  <= i_callback_id;
            r_ctx <= i_context_id;
        end
        if (i_cmd.pos_load) begin
            r_pos <= r_idx;
        end
        if (i_cmd.k_load) begin
            r_k <= r_idx;
        end
        if (i_cmd.pend_load) begin
            r_pend_cb  <= rd_cb;
            r_pend_ctx <= rd_ctx;
        end
        if (i_cmd.out_load) begin
            case (i_cmd.out_sel)
                OUT_OK: begin
                    r_kind   <= KIND_STATUS;
                    r_status <= ST_OK;
                    r_o_cb   <= '0;
                    r_o_ctx  <= '0;
                    r_last   <= 1'b1;
                end
                OUT_ERR: begin
                    r_kind   <= KIND_STATUS;
                    r_status <= ST_ERR;
                    r_o_cb   <= '0;
                    r_o_ctx  <= '0;
                    r_last   <= 1'b1;
                end
                OUT_PEND: begin
                    r_kind   <= KIND_FIRED;
                    r_status <= ST_OK;
                    r_o_cb   <= r_pend_cb;
                    r_o_ctx  <= r_pend_ctx;
                    r_last   <= i_cmd.out_last;
                end
                default: begin
                    r_kind   <= KIND_NONE;
                    r_status <= ST_OK;
                    r_o_cb   <= '0;
                    r_o_ctx  <= '0;
                    r_last   <= 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_cnt     <= '0;
            r_found   <= 1'b0;
            r_pend_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.idx_clr || i_cmd.k_load) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end else if (i_cmd.idx_dec) begin
                r_idx <= r_idx - CW'(1);
            end else if (i_cmd.idx_load_cnt) begin
                r_idx <= r_cnt;
            end

            if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_cnt <= r_cnt - CW'(1);
            end else if (i_cmd.cnt_sub_k) begin
                r_cnt <= r_cnt - r_k;
            end

            if (i_cmd.load_item) begin
                r_found  <= 1'b0;
                r_pend_v <= 1'b0;
            end else begin
                if (i_cmd.found_set) begin
                    r_found <= 1'b1;
                end
                if (i_cmd.pend_load) begin
                    r_pend_v <= 1'b1;
                end
            end

            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign out_free = !r_o_valid || !i_out_stall;

    always_comb begin
        o_sts            = '0;
        o_sts.op         = r_op;
        o_sts.idx_eq_cnt = (r_idx == r_cnt);
        o_sts.idx_last   = ({1'b0, r_idx} + (CW + 1)'(1)) >= {1'b0, r_cnt};
        o_sts.idx_gt_pos = (r_idx > r_pos);
        o_sts.cmp_done   = ({1'b0, r_idx} + {1'b0, r_k}) >= {1'b0, r_cnt};
        o_sts.key_match  = (rd_cb == r_cb) && (rd_ctx == r_ctx);
        o_sts.due_le_new = (rd_due <= r_due);
        o_sts.due_le_now = (rd_due <= r_now);
        o_sts.cb_zero    = (r_cb == '0);
        o_sts.full       = (r_cnt == CW'(MAX_TIMERS));
        o_sts.found      = r_found;
        o_sts.pend_v     = r_pend_v;
        o_sts.out_free   = out_free;
    end

    assign o_valid          = r_o_valid;
    assign o_kind           = r_kind;
    assign o_status         = r_status;
    assign o_fired_callback = r_o_cb;
    assign o_fired_context  = r_o_ctx;
    assign o_last           = r_last;

endmodule

// ===== rtl/core/sorted_timer_event_queue_core.sv =====
// Sorted timer event queue: up to MAX_TIMERS one-shot timers kept in due order in one RAM.
// Set/cancel: find and remove the key; set then scans for its slot and shifts entries up.
// Dispatch: scans entries that are due, emitting each, then compacts the rest down.
// One item at a time; the RAM's single read and write port sets the pace; output stalls add.
// Reset empties the queue (count to zero) and clears the FSM and output valid; no RAM sweep.
module sorted_timer_event_queue_core #(
    parameter int MAX_TIMERS = steq_pkg::MAX_TIMERS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_opcode,
    input  logic [steq_pkg::DUE_W-1:0]  i_now_ms,
    input  logic [steq_pkg::ID_W-1:0]   i_period_ms,
    input  logic [steq_pkg::ID_W-1:0]   i_callback_id,
    input  logic [steq_pkg::ID_W-1:0]   i_context_id,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_kind,
    output logic                        o_status,
    output logic [steq_pkg::ID_W-1:0]   o_fired_callback,
    output logic [steq_pkg::ID_W-1:0]   o_fired_context,
    output logic                        o_last
);
    import steq_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic ready;

    steq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_ready (ready),
        .o_cmd   (cmd)
    );

    steq_dp #(
        .MAX_TIMERS (MAX_TIMERS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_opcode         (i_opcode),
        .i_now_ms         (i_now_ms),
        .i_period_ms      (i_period_ms),
        .i_callback_id    (i_callback_id),
        .i_context_id     (i_context_id),
        .i_out_stall      (i_stall),
        .o_valid          (o_valid),
        .o_kind           (o_kind),
        .o_status         (o_status),
        .o_fired_callback (o_fired_callback),
        .o_fired_context  (o_fired_context),
        .o_last           (o_last)
    );

    assign o_stall = !ready;

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over an untaken word");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second word accepted before first finished");

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.cnt_inc |-> !sts.full)
        else $error("insert into full table");
`endif

endmodule
